### rtl/spq_pkg.sv
// Shared types, constants and scale tables of the scale pitch quantizer.
package spq_pkg;

  localparam int CMD_W    = 2;
  localparam int NOTE_W   = 7;
  localparam int STEP_W   = 7;
  localparam int OUT_W    = 9;
  localparam int CFG_W    = 4;
  localparam int DATA_W   = 32;
  localparam int ADDR_W   = 3;
  localparam int NUM_SCALES = 11;
  localparam int PC_NUM   = 12;
  localparam int MAX_DEG  = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_SNAP_SCALE = 2'd0,
    CMD_SNAP_CHORD = 2'd1,
    CMD_TRANSPOSE  = 2'd2,
    CMD_PASS       = 2'd3
  } cmd_t;

  // register index, taken from paddr[2]
  typedef enum logic {
    REG_ROOT  = 1'b0,
    REG_SCALE = 1'b1
  } reg_idx_t;

  localparam logic [3:0] SCALE_TAB [NUM_SCALES][PC_NUM] = '{
    '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10, 4'd11},
    '{4'd0, 4'd2, 4'd4, 4'd5, 4'd7, 4'd9, 4'd11, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
    '{4'd0, 4'd2, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
    '{4'd0, 4'd2, 4'd3, 4'd5, 4'd7, 4'd9, 4'd10, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
    '{4'd0, 4'd2, 4'd4, 4'd5, 4'd7, 4'd9, 4'd10, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
    '{4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
    '{4'd0, 4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
    '{4'd0, 4'd2, 4'd3, 4'd5, 4'd7, 4'd8, 4'd11, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
    '{4'd0, 4'd2, 4'd4, 4'd7, 4'd9, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
    '{4'd0, 4'd3, 4'd5, 4'd7, 4'd10, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
    '{4'd0, 4'd3, 4'd5, 4'd6, 4'd7, 4'd10, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0}
  };

  localparam logic [3:0] SCALE_LEN [NUM_SCALES] = '{
    4'd12, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd5, 4'd5, 4'd6
  };

  // out-of-range selects act as chromatic
  function automatic logic [3:0] scale_map(input logic [3:0] sel);
    return (sel < 4'(NUM_SCALES)) ? sel : 4'd0;
  endfunction

  function automatic logic [3:0] scale_deg(input logic [3:0] sel, input logic [3:0] idx);
    logic [3:0] s;
    s = scale_map(sel);
    if (idx >= 4'(PC_NUM)) return 4'd0;
    return SCALE_TAB[s][idx];
  endfunction

  function automatic logic [3:0] scale_len(input logic [3:0] sel);
    return SCALE_LEN[scale_map(sel)];
  endfunction

  // triad offsets: degrees 0, 2, 4, or C-E-G on the chromatic scale
  function automatic logic [3:0] chord_off(input logic [3:0] sel, input logic [1:0] j);
    logic [3:0] r;
    r = 4'd0;
    if (scale_len(sel) == 4'(PC_NUM)) begin
      case (j)
        2'd0:    r = 4'd0;
        2'd1:    r = 4'd4;
        2'd2:    r = 4'd7;
        default: r = 4'd0;
      endcase
    end else begin
      r = scale_deg(sel, {1'b0, j, 1'b0});
    end
    return r;
  endfunction

  // floor(1024/len): quotient estimate is exact or one low for u < 280
  function automatic logic [7:0] len_recip(input logic [3:0] len);
    logic [7:0] r;
    case (len)
      4'd5:    r = 8'd204;
      4'd6:    r = 8'd170;
      4'd7:    r = 8'd146;
      default: r = 8'd85;
    endcase
    return r;
  endfunction

  // bias of 210 divided by len; 210 is a multiple of 5, 6 and 7
  localparam int DIV_BIAS = 210;

  function automatic logic [7:0] len_bias(input logic [3:0] len);
    logic [7:0] r;
    case (len)
      4'd5:    r = 8'd42;
      4'd6:    r = 8'd35;
      4'd7:    r = 8'd30;
      default: r = 8'd17;
    endcase
    return r;
  endfunction

endpackage

### rtl/spq_if.sv
// Valid/ready channel interfaces for note requests and results.
interface spq_in_if
  import spq_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         cmd;
  logic [NOTE_W-1:0]        note_in;
  logic signed [STEP_W-1:0] step_count;

  modport source (output valid, cmd, note_in, step_count, input ready);
  modport sink   (input valid, cmd, note_in, step_count, output ready);
endinterface

interface spq_out_if
  import spq_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] note_out;

  modport source (output valid, note_out, input ready);
  modport sink   (input valid, note_out, output ready);
endinterface

### rtl/scale_pitch_quantizer.sv
// Top level of the scale pitch quantizer: five-stage note pipeline and APB registers.
//
//  channel  dir  handshake            payload
//  in_ch    in   valid/ready          cmd[1:0], note_in[6:0], step_count[6:0] signed
//  out_ch   out  valid/ready          note_out[8:0] signed
//  cfg_*    in   APB, pready tied 1   root_pitch @0x0, scale_select @0x4
//
// An item passes through every pipeline register before it shows on out_ch.valid;
// one item per cycle sustained while out_ch.ready stays high.
// The five pipeline registers are pitch class, distances, nearest pick, snap/reciprocal,
// and floor-mod and result mux.
// Each full stage holds when its successor is full and stalled; an empty stage always loads.
// Ready ripples back combinationally, so a stall lets items move only into empty stages.
// Synchronous active-low reset empties the pipeline and clears both registers.
module scale_pitch_quantizer
  import spq_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  spq_in_if.sink            in_ch,
  spq_out_if.source         out_ch,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [ADDR_W-1:0] cfg_paddr,
  input  logic [DATA_W-1:0] cfg_pwdata,
  output logic [DATA_W-1:0] cfg_prdata,
  output logic              cfg_pready
);

  // ---------------- configuration ----------------
  logic [CFG_W-1:0] root_r;
  logic [CFG_W-1:0] sel_r;
  logic             cfg_wr;
  reg_idx_t         cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_r <= '0;
      sel_r  <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_ROOT:  root_r <= cfg_pwdata[CFG_W-1:0];
        REG_SCALE: sel_r  <= cfg_pwdata[CFG_W-1:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_ROOT:  cfg_prdata = {{(DATA_W-CFG_W){1'b0}}, root_r};
      REG_SCALE: cfg_prdata = {{(DATA_W-CFG_W){1'b0}}, sel_r};
      default:   cfg_prdata = '0;
    endcase
  end

  // Config is to be changed only while idle; the block does not enforce this, and stages read it directly.
  logic [3:0] root_pc;
  logic [3:0] len;
  logic       chromatic;

  assign root_pc   = (root_r >= 4'(PC_NUM)) ? root_r - 4'(PC_NUM) : root_r;
  assign len       = scale_len(sel_r);
  assign chromatic = (len == 4'(PC_NUM));

  // ---------------- pipeline control ----------------
  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic en1, en2, en3, en4, en5;

  assign en5 = !v5_r || out_ch.ready;
  assign en4 = !v4_r || en5;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;

  assign in_ch.ready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_ch.valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
      if (en5) v5_r <= v4_r;
    end
  end

  // ---------------- stage 1: pitch class of the note ----------------
  // note / 12 as (note * 43) >> 9, exact for 0..127
  logic [12:0]              s1_prod;
  logic [3:0]               s1_q;
  logic [NOTE_W-1:0]        s1_rem;
  logic [3:0]               s1_pc_nxt;
  cmd_t                     s1_cmd_r;
  logic [NOTE_W-1:0]        s1_note_r;
  logic signed [STEP_W-1:0] s1_steps_r;
  logic [3:0]               s1_pc_r;

  assign s1_prod   = {6'd0, in_ch.note_in} * 13'd43;
  assign s1_q      = s1_prod[12:9];
  assign s1_rem    = in_ch.note_in - 7'(s1_q) * 7'(PC_NUM);
  assign s1_pc_nxt = s1_rem[3:0];

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_cmd_r   <= cmd_t'(in_ch.cmd);
      s1_note_r  <= in_ch.note_in;
      s1_steps_r <= in_ch.step_count;
      s1_pc_r    <= s1_pc_nxt;
    end
  end

  // ---------------- stage 2: circular distance to each degree ----------------
  logic signed [4:0]        s2_diff;
  logic [3:0]               s2_rel;
  logic [3:0]               s2_sdist_nxt [MAX_DEG];
  logic [3:0]               s2_cdist_nxt [3];
  logic [3:0]               s2_sdist_r   [MAX_DEG];
  logic [3:0]               s2_cdist_r   [3];
  cmd_t                     s2_cmd_r;
  logic [NOTE_W-1:0]        s2_note_r;
  logic signed [STEP_W-1:0] s2_steps_r;
  logic [3:0]               s2_pc_r;

  function automatic logic [3:0] circ_dist(input logic [3:0] a, input logic [3:0] b);
    logic [3:0] raw;
    raw = (a >= b) ? a - b : b - a;
    return (raw > 4'd6) ? 4'(PC_NUM) - raw : raw;
  endfunction

  assign s2_diff = $signed({1'b0, s1_pc_r}) - $signed({1'b0, root_pc});
  assign s2_rel  = s2_diff[4] ? 4'(s2_diff + 5'sd12) : s2_diff[3:0];

  always_comb begin
    for (int i = 0; i < MAX_DEG; i++) begin
      // degrees beyond the scale length never win
      if (4'(i) < len) s2_sdist_nxt[i] = circ_dist(s2_rel, scale_deg(sel_r, 4'(i)));
      else             s2_sdist_nxt[i] = 4'hf;
    end
    for (int j = 0; j < 3; j++) begin
      s2_cdist_nxt[j] = circ_dist(s2_rel, chord_off(sel_r, 2'(j)));
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_sdist_r <= s2_sdist_nxt;
      s2_cdist_r <= s2_cdist_nxt;
      s2_cmd_r   <= s1_cmd_r;
      s2_note_r  <= s1_note_r;
      s2_steps_r <= s1_steps_r;
      s2_pc_r    <= s1_pc_r;
    end
  end

  // ---------------- stage 3: nearest degree, first wins ties ----------------
  logic [2:0]               s3_di_nxt;
  logic [1:0]               s3_ci;
  logic [3:0]               s3_best;
  logic [3:0]               s3_cbest;
  logic [3:0]               s3_off_nxt;
  logic signed [7:0]        s3_total_nxt;
  logic [2:0]               s3_di_r;
  logic [3:0]               s3_off_r;
  logic signed [7:0]        s3_total_r;
  cmd_t                     s3_cmd_r;
  logic [NOTE_W-1:0]        s3_note_r;
  logic signed [STEP_W-1:0] s3_steps_r;
  logic [3:0]               s3_pc_r;

  always_comb begin
    s3_di_nxt = 3'd0;
    s3_best   = s2_sdist_r[0];
    for (int i = 1; i < MAX_DEG; i++) begin
      if (s2_sdist_r[i] < s3_best) begin
        s3_best   = s2_sdist_r[i];
        s3_di_nxt = 3'(i);
      end
    end
    s3_ci    = 2'd0;
    s3_cbest = s2_cdist_r[0];
    for (int j = 1; j < 3; j++) begin
      if (s2_cdist_r[j] < s3_cbest) begin
        s3_cbest = s2_cdist_r[j];
        s3_ci    = 2'(j);
      end
    end
    s3_off_nxt = (s2_cmd_r == CMD_SNAP_CHORD) ? chord_off(sel_r, s3_ci)
                                              : scale_deg(sel_r, {1'b0, s3_di_nxt});
    s3_total_nxt = $signed({5'd0, s3_di_nxt}) + 8'(s2_steps_r);
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_di_r    <= s3_di_nxt;
      s3_off_r   <= s3_off_nxt;
      s3_total_r <= s3_total_nxt;
      s3_cmd_r   <= s2_cmd_r;
      s3_note_r  <= s2_note_r;
      s3_steps_r <= s2_steps_r;
      s3_pc_r    <= s2_pc_r;
    end
  end

  // ---------------- stage 4: snap move, quotient estimate ----------------
  logic [4:0]               s4_tsum;
  logic [3:0]               s4_tgt;
  logic signed [5:0]        s4_m;
  logic signed [5:0]        s4_fold;
  logic signed [OUT_W-1:0]  s4_snap_nxt;
  logic [9:0]               s4_ubias;
  logic [8:0]               s4_u_nxt;
  logic [16:0]              s4_prod;
  logic [6:0]               s4_q0_nxt;
  logic signed [OUT_W-1:0]  s4_snap_r;
  logic [8:0]               s4_u_r;
  logic [6:0]               s4_q0_r;
  logic [2:0]               s4_di_r;
  cmd_t                     s4_cmd_r;
  logic [NOTE_W-1:0]        s4_note_r;
  logic signed [STEP_W-1:0] s4_steps_r;

  always_comb begin
    s4_tsum = {1'b0, root_pc} + {1'b0, s3_off_r};
    s4_tgt  = (s4_tsum >= 5'(PC_NUM)) ? 4'(s4_tsum - 5'(PC_NUM)) : s4_tsum[3:0];
    // move folded into -6..5
    s4_m    = $signed({2'b0, s4_tgt}) - $signed({2'b0, s3_pc_r}) + 6'sd6;
    if (s4_m < 0)                     s4_fold = s4_m + 6'sd12;
    else if (s4_m >= 6'sd12)          s4_fold = s4_m - 6'sd12;
    else                              s4_fold = s4_m;
    s4_snap_nxt = $signed({2'b0, s3_note_r}) + 9'(s4_fold - 6'sd6);
    // biased total keeps the floor division on a positive value
    s4_ubias  = 10'(s3_total_r) + 10'(DIV_BIAS);
    s4_u_nxt  = s4_ubias[8:0];
    s4_prod   = {8'd0, s4_u_nxt} * {9'd0, len_recip(len)};
    s4_q0_nxt = s4_prod[16:10];
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      s4_snap_r  <= s4_snap_nxt;
      s4_u_r     <= s4_u_nxt;
      s4_q0_r    <= s4_q0_nxt;
      s4_di_r    <= s3_di_r;
      s4_cmd_r   <= s3_cmd_r;
      s4_note_r  <= s3_note_r;
      s4_steps_r <= s3_steps_r;
    end
  end

  // ---------------- stage 5: floor mod, octave, result select ----------------
  logic [9:0]              s5_rem0;
  logic [9:0]              s5_rem;
  logic [6:0]              s5_q;
  logic signed [7:0]       s5_oct;
  logic signed [10:0]      s5_trans;
  logic signed [OUT_W-1:0] s5_out_nxt;
  logic signed [OUT_W-1:0] s5_out_r;

  always_comb begin
    s5_rem0 = {1'b0, s4_u_r} - 10'(s4_q0_r) * 10'(len);
    if (s5_rem0 >= 10'(len)) begin
      s5_rem = s5_rem0 - 10'(len);
      s5_q   = s4_q0_r + 7'd1;
    end else begin
      s5_rem = s5_rem0;
      s5_q   = s4_q0_r;
    end
    s5_oct   = $signed({1'b0, s5_q}) - $signed(len_bias(len));
    s5_trans = 11'(s4_snap_r)
             - $signed({7'd0, scale_deg(sel_r, {1'b0, s4_di_r})})
             + $signed({7'd0, scale_deg(sel_r, s5_rem[3:0])})
             + 11'(s5_oct) * 11'sd12;
    case (s4_cmd_r)
      CMD_SNAP_SCALE: s5_out_nxt = chromatic ? $signed({2'b0, s4_note_r}) : s4_snap_r;
      CMD_SNAP_CHORD: s5_out_nxt = s4_snap_r;
      CMD_TRANSPOSE:  s5_out_nxt = chromatic
                                   ? $signed({2'b0, s4_note_r}) + 9'(s4_steps_r)
                                   : s5_trans[OUT_W-1:0];
      default:        s5_out_nxt = $signed({2'b0, s4_note_r});
    endcase
  end

  always_ff @(posedge clk) begin
    if (en5) s5_out_r <= s5_out_nxt;
  end

  assign out_ch.valid    = v5_r;
  assign out_ch.note_out = s5_out_r;

endmodule
